// ===== hw/rtl/scs_pkg.sv =====
// Shared types, widths and constants for the stack calculator step unit.
// No dependencies; the interfaces and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  localparam int MODE_W          = 4;
  localparam int OPERAND_W       = 30;
  localparam int VALUE_W         = 31;
  localparam int PROD_W          = 2 * VALUE_W;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int LIMIT_MAG       = 1000000000;

  typedef enum logic [MODE_W-1:0] {
    M_START = 4'd0,
    M_NUM   = 4'd1,
    M_POP   = 4'd2,
    M_INV   = 4'd3,
    M_DUP   = 4'd4,
    M_SWP   = 4'd5,
    M_ADD   = 4'd6,
    M_SUB   = 4'd7,
    M_MUL   = 4'd8,
    M_DIV   = 4'd9,
    M_MOD   = 4'd10,
    M_END   = 4'd11
  } mode_t;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [VALUE_W-1:0]        mag_t;

  // magnitude of a stack value as an unsigned word
  function automatic mag_t mag(input value_t x);
    value_t n;
    n = -x;
    return x[VALUE_W-1] ? mag_t'(n) : mag_t'(x);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scs_req_if.sv =====
// Instruction channel: valid/ready handshake carrying mode and operand.
// Depends on scs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scs_req_if;
  logic                          valid;
  logic                          ready;
  logic [scs_pkg::MODE_W-1:0]    mode;
  logic [scs_pkg::OPERAND_W-1:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scs_rsp_if.sv =====
// Result channel: valid/ready handshake carrying the END result word.
// Depends on scs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [scs_pkg::VALUE_W-1:0]  result_value;
  logic                                result_error;

  modport source (output valid, output result_value, output result_error, input ready);
  modport sink   (input valid, input result_value, input result_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Gives quotient and remainder with a one-cycle done pulse. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module scs_div #(
  parameter int W = 31
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic      [W-1:0] quot,
  output logic      [W-1:0] rem
);

  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0] step;
  logic [W-1:0]     dvs;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem, quot[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvs  <= divisor;
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
        end else begin
          rem <= shifted[W-1:0];
        end
        quot <= {quot[W-2:0], ~diff[W]};
        if (step == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + CNT_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stack_calculator_step_unit.sv =====
// Top level of the stack calculator step unit: sequencer, stack RAM, shared ALU.
// Depends on scs_pkg, scs_req_if, scs_rsp_if, scs_ram and scs_div.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   mode[3:0], operand[29:0]
//  rsp      out  valid/ready   result_value[30:0] signed, result_error
//
// One word at a time. Every word passes decode; POP adds a load; SWP, ADD and SUB
// add a fetch; MUL a fetch and a product check; DIV and MOD a fetch and a wait on
// the bit-serial divider (31 steps). Top of stack lives in a register; deeper
// entries in a single-port-pair RAM with registered read data. Stack RAM is not
// cleared at reset. END holds in decode while an earlier result waits on rsp.
`timescale 1ns / 1ps
`default_nettype none

module stack_calculator_step_unit #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  scs_req_if.sink    req,
  scs_rsp_if.source  rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = scs_pkg::VALUE_W;
  localparam int PW = scs_pkg::PROD_W;
  localparam logic signed [PW-1:0] LIM_P = PW'(scs_pkg::LIMIT_MAG);
  localparam logic signed [VW:0]   LIM_S = (VW + 1)'(scs_pkg::LIMIT_MAG);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_LOAD,
    S_FETCH,
    S_MULCHK,
    S_DIVW
  } state_t;

  state_t                          state;
  scs_pkg::mode_t                  mode_q;
  logic [scs_pkg::OPERAND_W-1:0]   opnd_q;
  scs_pkg::value_t                 tos;
  logic [CW-1:0]                   cnt;
  logic                            err;
  logic                            sgn_sec;
  logic                            sgn_tos;
  logic signed [PW-1:0]            prod;

  logic                            out_valid;
  scs_pkg::value_t                 out_value;
  logic                            out_error;

  logic [CW-1:0]                   cnt_m1;
  logic [CW-1:0]                   cnt_m2;
  logic                            full;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [VW-1:0]                   ram_rdata;
  scs_pkg::value_t                 sec;
  logic signed [VW:0]              sum;
  logic                            sum_ovf;
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  scs_pkg::mag_t                   div_q;
  scs_pkg::mag_t                   div_r;
  scs_pkg::mag_t                   res_mag;
  logic                            res_neg;

  assign cnt_m1 = cnt - CW'(1);
  assign cnt_m2 = cnt - CW'(2);
  assign full   = (cnt == CW'(STACK_DEPTH));
  assign sec    = scs_pkg::value_t'(ram_rdata);

  // push spills the old top into RAM; swap writes it into the second entry's slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_m1[AW-1:0];
    if (state == S_DEC && !err && cnt != '0 && !full &&
        (mode_q == scs_pkg::M_NUM || mode_q == scs_pkg::M_DUP)) begin
      ram_we = 1'b1;
    end
    if (state == S_FETCH && mode_q == scs_pkg::M_SWP) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_m2[AW-1:0];
    end
  end

  scs_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (mode_q == scs_pkg::M_SUB) begin
      sum = {sec[VW-1], sec} - {tos[VW-1], tos};
    end else begin
      sum = {sec[VW-1], sec} + {tos[VW-1], tos};
    end
  end
  assign sum_ovf = (sum > LIM_S) || (sum < -LIM_S);

  assign div_start = (state == S_FETCH) && (tos != '0) &&
                     (mode_q == scs_pkg::M_DIV || mode_q == scs_pkg::M_MOD);

  scs_div #(
    .W (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scs_pkg::mag(sec)),
    .divisor  (scs_pkg::mag(tos)),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // DIV truncates toward zero; MOD follows the dividend's sign
  assign res_mag = (mode_q == scs_pkg::M_DIV) ? div_q : div_r;
  assign res_neg = (mode_q == scs_pkg::M_DIV) ? (sgn_sec ^ sgn_tos) : sgn_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_q <= scs_pkg::mode_t'(req.mode);
            opnd_q <= req.operand;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_IDLE;
          case (mode_q)
            scs_pkg::M_START: begin
              cnt <= CW'(1);
              err <= 1'b0;
              tos <= {1'b0, opnd_q};
            end
            scs_pkg::M_END: begin
              if (out_valid && !rsp.ready) begin
                state <= S_DEC;
              end else begin
                out_valid <= 1'b1;
                out_error <= err || (cnt != CW'(1));
                out_value <= (!err && cnt == CW'(1)) ? tos : '0;
              end
            end
            scs_pkg::M_NUM: begin
              if (!err) begin
                if (full) begin
                  err <= 1'b1;
                end else begin
                  tos <= {1'b0, opnd_q};
                  cnt <= cnt + CW'(1);
                end
              end
            end
            scs_pkg::M_POP: begin
              if (!err) begin
                if (cnt == '0) begin
                  err <= 1'b1;
                end else begin
                  cnt <= cnt_m1;
                  if (cnt >= CW'(2)) begin
                    state <= S_LOAD;
                  end
                end
              end
            end
            scs_pkg::M_INV: begin
              if (!err) begin
                if (cnt == '0) begin
                  err <= 1'b1;
                end else begin
                  tos <= -tos;
                end
              end
            end
            scs_pkg::M_DUP: begin
              if (!err) begin
                if (cnt == '0 || full) begin
                  err <= 1'b1;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
            end
            scs_pkg::M_SWP, scs_pkg::M_ADD, scs_pkg::M_SUB,
            scs_pkg::M_MUL, scs_pkg::M_DIV, scs_pkg::M_MOD: begin
              if (!err) begin
                if (cnt < CW'(2)) begin
                  err <= 1'b1;
                end else begin
                  state <= S_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_LOAD: begin
          tos   <= sec;
          state <= S_IDLE;
        end
        S_FETCH: begin
          state <= S_IDLE;
          case (mode_q)
            scs_pkg::M_SWP: begin
              tos <= sec;
            end
            scs_pkg::M_ADD, scs_pkg::M_SUB: begin
              if (sum_ovf) begin
                err <= 1'b1;
              end else begin
                tos <= sum[VW-1:0];
                cnt <= cnt_m1;
              end
            end
            scs_pkg::M_MUL: begin
              prod  <= sec * tos;
              state <= S_MULCHK;
            end
            scs_pkg::M_DIV, scs_pkg::M_MOD: begin
              if (tos == '0) begin
                err <= 1'b1;
              end else begin
                sgn_sec <= sec[VW-1];
                sgn_tos <= tos[VW-1];
                state   <= S_DIVW;
              end
            end
            default: begin
            end
          endcase
        end
        S_MULCHK: begin
          state <= S_IDLE;
          if (prod > LIM_P || prod < -LIM_P) begin
            err <= 1'b1;
          end else begin
            tos <= prod[VW-1:0];
            cnt <= cnt_m1;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            tos   <= res_neg ? -res_mag : res_mag;
            cnt   <= cnt_m1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.result_error = out_error;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_value == '0)
    else $error("error result carries a nonzero value");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIVW)
    else $error("divider running outside divide wait");

  a_start_init: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.mode == scs_pkg::M_START |-> ##2 (cnt == CW'(1) && !err))
    else $error("start did not leave one entry and a clear flag");

endmodule

`default_nettype wire

// ===== verif/stack_calculator_step_unit_test.sv =====
// Testbench for stack_calculator_step_unit: directed and random stack programs, each result
// word checked against a behavioral stack machine kept in a scoreboard class.
// Depends on scs_pkg, scs_req_if, scs_rsp_if and the RTL top level.
`timescale 1ns / 1ps

typedef struct packed {
  scs_pkg::value_t value;
  logic            error;
} calc_result_t;

class stack_machine_checker;
  scs_pkg::value_t stack_mem [scs_pkg::STACK_DEPTH_DEF];
  logic [10:0]     depth;
  logic            err_flag;
  calc_result_t    expected_results [$];
  int              fail_count;

  function void push_value(scs_pkg::value_t v);
    if (depth >= scs_pkg::STACK_DEPTH_DEF) begin
      err_flag = 1'b1;
      return;
    end
    stack_mem[depth] = v;
    depth = depth + 11'd1;
  endfunction

  // one accepted instruction word; END queues the result it must produce
  function void note_instruction(logic [scs_pkg::MODE_W-1:0] mode,
                                 logic [scs_pkg::OPERAND_W-1:0] operand);
    calc_result_t res;
    longint top;
    longint sec;
    longint r;
    if (mode == scs_pkg::M_START) begin
      depth = '0;
      err_flag = 1'b0;
      push_value(scs_pkg::value_t'({1'b0, operand}));
      return;
    end
    if (mode == scs_pkg::M_END) begin
      if (!err_flag && depth == 11'd1) begin
        res.value = stack_mem[0];
        res.error = 1'b0;
      end else begin
        res.value = '0;
        res.error = 1'b1;
      end
      expected_results.insert(expected_results.size(), res);
      return;
    end
    if (mode > scs_pkg::M_END || err_flag) return;
    if (mode == scs_pkg::M_NUM) begin
      push_value(scs_pkg::value_t'({1'b0, operand}));
      return;
    end
    if (mode <= scs_pkg::M_DUP) begin
      if (depth < 11'd1) begin
        err_flag = 1'b1;
        return;
      end
      case (mode)
        scs_pkg::M_POP: depth = depth - 11'd1;
        scs_pkg::M_INV: stack_mem[depth - 11'd1] = -stack_mem[depth - 11'd1];
        default:        push_value(stack_mem[depth - 11'd1]);
      endcase
      return;
    end
    if (depth < 11'd2) begin
      err_flag = 1'b1;
      return;
    end
    top = stack_mem[depth - 11'd1];
    sec = stack_mem[depth - 11'd2];
    if (mode == scs_pkg::M_SWP) begin
      stack_mem[depth - 11'd1] = scs_pkg::value_t'(sec);
      stack_mem[depth - 11'd2] = scs_pkg::value_t'(top);
      return;
    end
    if ((mode == scs_pkg::M_DIV || mode == scs_pkg::M_MOD) && top == 0) begin
      err_flag = 1'b1;
      return;
    end
    // longint / and % truncate toward zero, remainder follows the dividend
    case (mode)
      scs_pkg::M_ADD: r = sec + top;
      scs_pkg::M_SUB: r = sec - top;
      scs_pkg::M_MUL: r = sec * top;
      scs_pkg::M_DIV: r = sec / top;
      default:        r = sec % top;
    endcase
    if (mode <= scs_pkg::M_MUL &&
        (r > scs_pkg::LIMIT_MAG || r < -scs_pkg::LIMIT_MAG)) begin
      err_flag = 1'b1;
      return;
    end
    depth = depth - 11'd1;
    stack_mem[depth - 11'd1] = scs_pkg::value_t'(r);
  endfunction

  function void check_result(scs_pkg::value_t value, logic error);
    calc_result_t exp_res;
    if (expected_results.size() == 0) begin
      $display("%t: unexpected result word value %0d error %0b", $time, value, error);
      fail_count++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (value !== exp_res.value) begin
      $display("%t: result_value expected %0d, got %0d", $time, exp_res.value, value);
      fail_count++;
    end
    if (error !== exp_res.error) begin
      $display("%t: result_error expected %0b, got %0b", $time, exp_res.error, error);
      fail_count++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module stack_calculator_step_unit_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_ITEMS   = 670;
  localparam int CALM_ITEMS     = 100;
  localparam logic [scs_pkg::MODE_W-1:0] M_UNUSED_LAST = 4'd15;

  logic clk;
  logic rst;
  bit   src_idle;
  bit   snk_idle;
  bit   hold_long;
  int   sent_words;
  int   quiet_cycles;
  stack_machine_checker sb;

  scs_req_if req_ch ();
  scs_rsp_if rsp_ch ();

  stack_calculator_step_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stack_calculator_step_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.result_value, rsp_ch.result_error);
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [scs_pkg::OPERAND_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return scs_pkg::OPERAND_W'($urandom_range(0, 20));
      6, 7:             return scs_pkg::OPERAND_W'($urandom_range(0, 40000));
      8:                return scs_pkg::OPERAND_W'($urandom_range(0, scs_pkg::LIMIT_MAG));
      default:          return scs_pkg::OPERAND_W'($urandom);
    endcase
  endfunction

  // called at a clock edge; returns at the edge where the word is taken
  task automatic send_word(input logic [scs_pkg::MODE_W-1:0] mode,
                           input logic [scs_pkg::OPERAND_W-1:0] operand);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.operand <= operand;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_instruction(mode, operand);
    if (mode <= scs_pkg::M_END) sent_words++;
  endtask

  task automatic wait_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly well-formed programs; sloppy ones skip START, inject any mode, leave junk
  task automatic run_program(input int ops, input bit sloppy);
    int d;
    logic [scs_pkg::MODE_W-1:0] m;
    d = 0;
    if (!sloppy || $urandom_range(0, 2) != 0) begin
      send_word(scs_pkg::M_START, pick_operand());
      d = 1;
    end
    repeat (ops) begin
      if (sloppy && $urandom_range(0, 3) == 0)
        m = scs_pkg::MODE_W'($urandom_range(0, 15));
      else if (d == 0)
        m = scs_pkg::M_NUM;
      else if (d == 1)
        m = ($urandom_range(0, 2) == 0) ?
            scs_pkg::mode_t'($urandom_range(scs_pkg::M_INV, scs_pkg::M_DUP)) :
            scs_pkg::M_NUM;
      else if (d >= 6)
        m = scs_pkg::mode_t'($urandom_range(scs_pkg::M_SWP, scs_pkg::M_MOD));
      else
        m = scs_pkg::mode_t'($urandom_range(scs_pkg::M_NUM, scs_pkg::M_MOD));
      send_word(m, pick_operand());
      case (m)
        scs_pkg::M_START:                d = 1;
        scs_pkg::M_NUM, scs_pkg::M_DUP:  d++;
        scs_pkg::M_POP, scs_pkg::M_ADD, scs_pkg::M_SUB,
        scs_pkg::M_MUL, scs_pkg::M_DIV, scs_pkg::M_MOD: if (d > 0) d--;
        default: ;
      endcase
    end
    while (d > 1 && !(sloppy && $urandom_range(0, 1) == 0)) begin
      send_word(scs_pkg::mode_t'($urandom_range(scs_pkg::M_ADD, scs_pkg::M_MOD)),
                pick_operand());
      d--;
    end
    send_word(scs_pkg::M_END, pick_operand());
  endtask

  initial begin
    int  start_words;
    bit  pressed;
    bit  calm;
    sb = new();
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.mode    <= scs_pkg::M_START;
    req_ch.operand <= '0;
    src_idle  = 1'b0;
    snk_idle  = 1'b0;
    hold_long = 1'b0;
    pressed   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no START yet: stack begins empty
    send_word(scs_pkg::M_NUM, 30'd7);
    send_word(M_UNUSED_LAST, '1);
    send_word(scs_pkg::M_END, '0);
    // operand above the nominal range, then negated
    send_word(scs_pkg::M_START, '1);
    send_word(scs_pkg::M_INV, '0);
    send_word(scs_pkg::M_END, '1);
    // underflow, later words ignored until END
    send_word(scs_pkg::M_START, '0);
    send_word(scs_pkg::M_POP, '0);
    send_word(scs_pkg::M_POP, '0);
    send_word(scs_pkg::M_NUM, 30'd5);
    send_word(scs_pkg::M_END, '0);
    // magnitude overflow on ADD
    send_word(scs_pkg::M_START, 30'(scs_pkg::LIMIT_MAG));
    send_word(scs_pkg::M_DUP, '0);
    send_word(scs_pkg::M_ADD, '0);
    send_word(scs_pkg::M_END, '0);
    // signed DIV and MOD, SWP, MUL, SUB, then divide by zero
    send_word(scs_pkg::M_START, 30'd7);
    send_word(scs_pkg::M_INV, '0);
    send_word(scs_pkg::M_NUM, 30'd2);
    send_word(scs_pkg::M_DIV, '0);
    send_word(scs_pkg::M_NUM, 30'd2);
    send_word(scs_pkg::M_SWP, '0);
    send_word(scs_pkg::M_MOD, '0);
    send_word(scs_pkg::M_DUP, '0);
    send_word(scs_pkg::M_MUL, '0);
    send_word(scs_pkg::M_NUM, '0);
    send_word(scs_pkg::M_SUB, '0);
    send_word(scs_pkg::M_NUM, '0);
    send_word(scs_pkg::M_DIV, '0);
    send_word(scs_pkg::M_END, '0);
    wait_results();

    start_words = sent_words;
    while (sent_words < start_words + RANDOM_ITEMS) begin
      calm = (sent_words >= start_words + RANDOM_ITEMS - CALM_ITEMS);
      src_idle = !calm && $urandom_range(0, 3) != 0;
      snk_idle = !calm && $urandom_range(0, 3) != 0;
      // long receiver hold while programs keep coming
      if (!pressed && sent_words >= start_words + 200) begin
        hold_long = 1'b1;
        pressed = 1'b1;
      end
      run_program($urandom_range(1, 10), $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 15) == 0) wait_results();
    end

    wait_results();
    repeat (50) @(posedge clk);
    if (sb.fail_count == 0)
      $display("stack_calculator_step_unit_test: PASS");
    else
      $display("stack_calculator_step_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/scs_pkg.sv
hw/rtl/scs_req_if.sv
hw/rtl/scs_rsp_if.sv
hw/rtl/scs_ram.sv
hw/rtl/scs_div.sv
hw/rtl/stack_calculator_step_unit.sv
verif/stack_calculator_step_unit_test.sv
